/* rtl/core/dltq_pkg.sv */
// Shared types and constants of the delta-list timer queue.
package dltq_pkg;
   localparam int QueueDepth = 32;
   localparam int NumSlots = 2 * QueueDepth;
   localparam int SlotBits = $clog2(NumSlots);
   localparam int TaskBits = 8;
   localparam int DeltaBits = 32;

   typedef enum logic [2:0] {
      MODE_FINE_DELAY   = 3'd0,
      MODE_COARSE_DELAY = 3'd1,
      MODE_READ_TIME    = 3'd2,
      MODE_FINE_TICK    = 3'd3,
      MODE_COARSE_TICK  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_TIME   = 2'd0,
      KIND_WAKE   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP,
      ST_WALK,
      ST_LINK,
      ST_LINK_PREV,
      ST_TICK_RD,
      ST_TICK_CHECK,
      ST_OUT
   } state_type;

   // Result staged by the sequencer for the output register.
   typedef struct packed {
      logic [1:0]           kind;
      logic [TaskBits-1:0]  task_id;
      logic [DeltaBits-1:0] time_value;
      logic                 last;
   } result_type;
endpackage

/* rtl/core/dltq_ram.sv */
// Generic RAM with one write port and one registered read port.
module dltq_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/delta_list_timer_queue_unit.sv */
// Top level of the delta-list timer queue: sequencer, slot memories and link memory.
//
//  channel | ports  | direction | item fields
//  req     | req_t* | in        | mode (tuser); task_id, delay (tdata)
//  rsp     | rsp_t* | out       | kind (tuser); task_id_res, time_value (tdata); last (tlast)
//
// After reset a clearing pass links the free lists of all 64 slots; req_tready stays low.
// A delay request pops a free slot, walks past the queued entries and links the new entry
// in, with a further link write when it lands behind an entry.
// A tick checks the queue head for each wake and sends each wake through the output state;
// no result comes when nothing wakes; a time reply or a rejection goes straight to output.
// Each result waits in the output state while rsp_tready is low; req_tready is high
// only while the sequencer is idle.
module delta_list_timer_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // mode[2:0]
   input  logic [39:0] req_tdata,   // task_id[7:0], delay[38:8], zero fill
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic [39:0] rsp_tdata,   // task_id_res[7:0], time_value[39:8]
   output logic        rsp_tlast
);
   localparam int SB = dltq_pkg::SlotBits;
   localparam int DB = dltq_pkg::DeltaBits;
   localparam int TB = dltq_pkg::TaskBits;
   localparam int NS = dltq_pkg::NumSlots;

   dltq_pkg::state_type state_ff, state_in;
   logic [TB-1:0] tid_ff, tid_in;
   logic [DB-1:0] dly_ff, dly_in;
   logic          q_ff, q_in;
   logic [SB-1:0] node_ff, node_in, cur_ff, cur_in, prev_ff, prev_in;
   logic          cur_ok_ff, cur_ok_in, prev_ok_ff, prev_ok_in;
   logic [5:0]    steps_ff, steps_in;
   logic [5:0]    nwake_ff, nwake_in;
   logic          tick_first_ff, tick_first_in;
   logic          wake_pend_ff, wake_pend_in;
   logic [SB-1:0] init_ff, init_in;
   logic [DB-1:0] tick_count_ff, tick_count_in;
   dltq_pkg::result_type res_ff, res_in;

   logic [SB-1:0] head_ff [2];
   logic          head_ok_ff [2];
   logic [SB-1:0] free_ff [2];
   logic          free_ok_ff [2];

   // Head and free-list register writes produced by the sequencer.
   logic          hw_en, hw_ok, fw_en, fw_ok;
   logic [SB-1:0] hw_data, fw_data;

   logic          dw_en, tw_en, lw_en;
   logic [SB-1:0] dw_addr, lw_addr, d_raddr, t_raddr, l_raddr;
   logic [DB-1:0] dw_data, d_rdata;
   logic [TB-1:0] t_rdata;
   logic [SB:0]   lw_data, l_rdata;   // valid bit above the next slot
   logic [SB-1:0] l_next;
   logic          l_ok;

   logic          q_req;
   logic [DB-1:0] sub_a, sub_b, diff;
   logic          dly_gt, walk_adv, wake, wake_last;

   dltq_ram #(.Width(DB), .Depth(NS)) u_delta (
      .clock(clock), .wr_en(dw_en), .wr_addr(dw_addr), .wr_data(dw_data),
      .rd_addr(d_raddr), .rd_data(d_rdata)
   );
   dltq_ram #(.Width(TB), .Depth(NS)) u_task (
      .clock(clock), .wr_en(tw_en), .wr_addr(node_ff), .wr_data(tid_ff),
      .rd_addr(t_raddr), .rd_data(t_rdata)
   );
   dltq_ram #(.Width(SB + 1), .Depth(NS)) u_link (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
      .rd_addr(l_raddr), .rd_data(l_rdata)
   );

   assign l_next = l_rdata[SB-1:0];
   assign l_ok   = l_rdata[SB];
   assign q_req  = (req_tuser == dltq_pkg::MODE_COARSE_DELAY)
                || (req_tuser == dltq_pkg::MODE_COARSE_TICK);

   // The one shared subtract/compare unit.
   assign dly_gt   = dly_ff > d_rdata;
   assign walk_adv = dly_gt && steps_ff < 6'(dltq_pkg::QueueDepth);

   always_comb begin
      sub_a = d_rdata;
      sub_b = DB'(1);
      if (state_ff == dltq_pkg::ST_WALK) begin
         sub_a = walk_adv ? dly_ff : d_rdata;
         sub_b = walk_adv ? d_rdata : dly_ff;
      end
   end

   assign diff = sub_a - sub_b;

   assign wake      = d_rdata == '0 || (tick_first_ff && d_rdata == DB'(1));
   assign wake_last = !l_ok || (nwake_ff + 6'd1 == 6'(dltq_pkg::QueueDepth));

   assign req_tready = (state_ff == dltq_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == dltq_pkg::ST_OUT);
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {res_ff.time_value, res_ff.task_id};
   assign rsp_tlast  = res_ff.last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dltq_pkg::ST_INIT: begin
            if (init_ff == SB'(NS - 1)) begin
               state_in = dltq_pkg::ST_IDLE;
            end
         end
         dltq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  dltq_pkg::MODE_FINE_DELAY, dltq_pkg::MODE_COARSE_DELAY: begin
                     state_in = free_ok_ff[q_req] ? dltq_pkg::ST_POP : dltq_pkg::ST_OUT;
                  end
                  dltq_pkg::MODE_READ_TIME: state_in = dltq_pkg::ST_OUT;
                  dltq_pkg::MODE_FINE_TICK, dltq_pkg::MODE_COARSE_TICK: begin
                     state_in = head_ok_ff[q_req] ? dltq_pkg::ST_TICK_RD : dltq_pkg::ST_IDLE;
                  end
                  default: state_in = dltq_pkg::ST_IDLE;
               endcase
            end
         end
         dltq_pkg::ST_POP: state_in = cur_ok_ff ? dltq_pkg::ST_WALK : dltq_pkg::ST_LINK;
         dltq_pkg::ST_WALK: begin
            if (walk_adv && l_ok) begin
               state_in = dltq_pkg::ST_WALK;
            end else begin
               state_in = dltq_pkg::ST_LINK;
            end
         end
         dltq_pkg::ST_LINK: begin
            state_in = prev_ok_ff ? dltq_pkg::ST_LINK_PREV : dltq_pkg::ST_IDLE;
         end
         dltq_pkg::ST_LINK_PREV: state_in = dltq_pkg::ST_IDLE;
         dltq_pkg::ST_TICK_RD:   state_in = dltq_pkg::ST_TICK_CHECK;
         dltq_pkg::ST_TICK_CHECK: begin
            if (wake_pend_ff) begin
               state_in = dltq_pkg::ST_OUT;
            end else if (wake) begin
               state_in = wake_last ? dltq_pkg::ST_OUT : dltq_pkg::ST_TICK_RD;
            end else begin
               state_in = dltq_pkg::ST_IDLE;
            end
         end
         dltq_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = res_ff.last ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TICK_RD;
            end
         end
         default: state_in = dltq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      tid_in = tid_ff; dly_in = dly_ff; q_in = q_ff;
      node_in = node_ff; cur_in = cur_ff; prev_in = prev_ff;
      cur_ok_in = cur_ok_ff; prev_ok_in = prev_ok_ff; steps_in = steps_ff;
      nwake_in = nwake_ff; tick_first_in = tick_first_ff; wake_pend_in = wake_pend_ff;
      init_in = init_ff; tick_count_in = tick_count_ff; res_in = res_ff;
      hw_en = 1'b0; hw_ok = 1'b0; hw_data = '0;
      fw_en = 1'b0; fw_ok = 1'b0; fw_data = '0;
      dw_en = 1'b0; dw_addr = '0; dw_data = '0; tw_en = 1'b0;
      lw_en = 1'b0; lw_addr = '0; lw_data = '0;
      d_raddr = cur_ff; l_raddr = cur_ff; t_raddr = head_ff[q_ff];
      unique case (state_ff)
         dltq_pkg::ST_INIT: begin
            // Each slot links to the next one of its queue; a queue's last slot has none.
            lw_en = 1'b1; lw_addr = init_ff;
            lw_data = {init_ff[SB-2:0] != '1, init_ff + SB'(1)};
            init_in = init_ff + SB'(1);
         end
         dltq_pkg::ST_IDLE: begin
            l_raddr = free_ff[q_req];
            if (req_tvalid) begin
               tid_in = req_tdata[7:0];
               dly_in = {1'b0, req_tdata[38:8]};
               q_in = q_req;
               node_in = free_ff[q_req];
               cur_in = head_ff[q_req];
               cur_ok_in = head_ok_ff[q_req];
               prev_ok_in = 1'b0; steps_in = '0; nwake_in = '0;
               tick_first_in = 1'b1; wake_pend_in = 1'b0;
               res_in.task_id = req_tdata[7:0];
               res_in.time_value = '0;
               res_in.last = 1'b1;
               res_in.kind = dltq_pkg::KIND_REJECT;
               if (req_tuser == dltq_pkg::MODE_READ_TIME) begin
                  res_in.kind = dltq_pkg::KIND_TIME;
                  res_in.task_id = '0;
                  res_in.time_value = tick_count_ff;
               end
               if (req_tuser == dltq_pkg::MODE_FINE_TICK) begin
                  tick_count_in = tick_count_ff + DB'(1);
               end
            end
         end
         dltq_pkg::ST_POP: begin
            // The free head's link arrives now, while the queue head is read for the walk.
            fw_en = 1'b1; fw_data = l_next; fw_ok = l_ok;
         end
         dltq_pkg::ST_WALK: begin
            if (walk_adv) begin
               dly_in = diff;
               prev_in = cur_ff; prev_ok_in = 1'b1;
               cur_ok_in = l_ok;
               cur_in = l_next;
               steps_in = steps_ff + 6'd1;
               d_raddr = l_next; l_raddr = l_next;
            end else begin
               // Successor found: reduce it by the new entry's delta.
               dw_en = 1'b1; dw_addr = cur_ff; dw_data = diff;
            end
         end
         dltq_pkg::ST_LINK: begin
            dw_en = 1'b1; dw_addr = node_ff; dw_data = dly_ff;
            tw_en = 1'b1;
            lw_en = 1'b1; lw_addr = node_ff; lw_data = {cur_ok_ff, cur_ff};
            if (!prev_ok_ff) begin
               hw_en = 1'b1; hw_data = node_ff; hw_ok = 1'b1;
            end
         end
         dltq_pkg::ST_LINK_PREV: begin
            lw_en = 1'b1; lw_addr = prev_ff; lw_data = {1'b1, node_ff};
         end
         dltq_pkg::ST_TICK_RD: begin
            d_raddr = head_ff[q_ff]; l_raddr = head_ff[q_ff];
         end
         dltq_pkg::ST_TICK_CHECK: begin
            wake_pend_in = 1'b0;
            if (wake_pend_ff) begin
               // The entry after a woken one is only looked at; a nonzero delta ends the run.
               res_in.last = (d_rdata != '0);
            end else begin
               tick_first_in = 1'b0;
               if (tick_first_ff && d_rdata != '0) begin
                  dw_en = 1'b1; dw_addr = head_ff[q_ff]; dw_data = diff;
               end
               if (wake) begin
                  res_in.kind = dltq_pkg::KIND_WAKE;
                  res_in.task_id = t_rdata;
                  res_in.time_value = '0;
                  res_in.last = wake_last;
                  nwake_in = nwake_ff + 6'd1;
                  wake_pend_in = !wake_last;
                  // Unlink the head and return it to the free list.
                  hw_en = 1'b1; hw_data = l_next; hw_ok = l_ok;
                  lw_en = 1'b1; lw_addr = head_ff[q_ff];
                  lw_data = {free_ok_ff[q_ff], free_ff[q_ff]};
                  fw_en = 1'b1; fw_data = head_ff[q_ff]; fw_ok = 1'b1;
               end
            end
         end
         dltq_pkg::ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dltq_pkg::ST_INIT;
         init_ff <= '0;
         tick_count_ff <= '0;
         for (int q = 0; q < 2; q++) begin
            head_ff[q] <= '0; head_ok_ff[q] <= 1'b0;
            free_ff[q] <= SB'(q * dltq_pkg::QueueDepth); free_ok_ff[q] <= 1'b1;
         end
         res_ff <= '0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_in;
         tick_count_ff <= tick_count_in;
         res_ff <= res_in;
         if (hw_en) begin
            head_ff[q_ff] <= hw_data; head_ok_ff[q_ff] <= hw_ok;
         end
         if (fw_en) begin
            free_ff[q_ff] <= fw_data; free_ok_ff[q_ff] <= fw_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in; dly_ff <= dly_in; q_ff <= q_in;
      node_ff <= node_in; cur_ff <= cur_in; prev_ff <= prev_in;
      cur_ok_ff <= cur_ok_in; prev_ok_ff <= prev_ok_in; steps_ff <= steps_in;
      nwake_ff <= nwake_in; tick_first_ff <= tick_first_in; wake_pend_ff <= wake_pend_in;
   end
endmodule
